// ===== hdl/mavg_pkg.sv =====
// ----------------------------------------------------------------------------
// mavg_pkg: shared constants and types for the moving-average filter
// Field widths, register indexes and the update word passed to the
// averaging state.
// ----------------------------------------------------------------------------
`default_nettype none

package mavg_pkg;

  localparam int MAX_TAPS    = 16;
  localparam int SAMPLE_W    = 16;
  // tap_count as written on the config port
  localparam int TAP_FIELD_W = 5;
  // holds 1..MAX_TAPS
  localparam int TAP_W       = $clog2(MAX_TAPS + 1);
  // ring position 0..MAX_TAPS-1
  localparam int POS_W       = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int SUM_W       = SAMPLE_W + POS_W;
  localparam int DCNT_W      = $clog2(SUM_W + 1);

  localparam int CFG_IDX_W   = 8;
  localparam int CFG_DATA_W  = 8;

  localparam logic [CFG_IDX_W-1:0] REG_FILTER_MODE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_TAP_COUNT   = CFG_IDX_W'(1);

  localparam logic MODE_BYPASS  = 1'b0;
  localparam logic MODE_AVERAGE = 1'b1;

  typedef struct packed {
    logic                upd;
    logic [SAMPLE_W-1:0] sample;
  } mavg_upd_t;

endpackage

`default_nettype wire

// ===== hdl/mavg_in_if.sv =====
// ----------------------------------------------------------------------------
// mavg_in_if: input sample channel
// valid/ready handshake carrying one sample word.
// ----------------------------------------------------------------------------
`default_nettype none

interface mavg_in_if
  import mavg_pkg::*;
  ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

`default_nettype wire

// ===== hdl/mavg_out_if.sv =====
// ----------------------------------------------------------------------------
// mavg_out_if: output sample channel
// valid/ready handshake carrying one result word.
// ----------------------------------------------------------------------------
`default_nettype none

interface mavg_out_if
  import mavg_pkg::*;
  ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

`default_nettype wire

// ===== hdl/mavg_cfg_if.sv =====
// ----------------------------------------------------------------------------
// mavg_cfg_if: configuration write channel
// valid/ready handshake carrying a register index and write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface mavg_cfg_if
  import mavg_pkg::*;
  ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/mavg_state.sv =====
// ----------------------------------------------------------------------------
// mavg_state: configuration registers and averaging state
// Holds mode, tap count, sample ring, running sum, write position and
// fill count. One update per averaged sample.
// ----------------------------------------------------------------------------
`default_nettype none

module mavg_state
  import mavg_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  mavg_cfg_if.sink         cfg,
  input  wire mavg_upd_t   upd,
  output logic             mode,
  output logic [SUM_W-1:0] sum,
  output logic [TAP_W-1:0] fill
);

  logic [SAMPLE_W-1:0] ring [MAX_TAPS];
  logic [TAP_W-1:0]    tap;
  logic [POS_W-1:0]    wp;

  logic                full;
  logic [SAMPLE_W-1:0] oldest;
  logic [SUM_W-1:0]    sum_next;
  logic [TAP_W-1:0]    wp_inc;
  logic [POS_W-1:0]    wp_next;
  logic [TAP_W-1:0]    fill_next;
  logic [TAP_FIELD_W-1:0] tap_wr;
  logic [TAP_W-1:0]    tap_clamped;

  assign cfg.ready = 1'b1;

  always_comb begin
    full      = (fill == tap);
    oldest    = full ? ring[wp] : '0;
    sum_next  = sum - SUM_W'(oldest) + SUM_W'(upd.sample);
    wp_inc    = TAP_W'(wp) + TAP_W'(1);
    wp_next   = (wp_inc >= tap) ? '0 : wp_inc[POS_W-1:0];
    fill_next = full ? fill : fill + TAP_W'(1);
  end

  // clamp tap_count into 1..MAX_TAPS
  always_comb begin
    tap_wr = cfg.data[TAP_FIELD_W-1:0];
    if (tap_wr == '0) begin
      tap_clamped = TAP_W'(1);
    end else if (int'(tap_wr) > MAX_TAPS) begin
      tap_clamped = TAP_W'(MAX_TAPS);
    end else begin
      tap_clamped = TAP_W'(tap_wr);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_BYPASS;
      tap  <= TAP_W'(1);
      sum  <= '0;
      wp   <= '0;
      fill <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_FILTER_MODE: begin
          mode <= cfg.data[0];
          sum  <= '0;
          wp   <= '0;
          fill <= '0;
        end
        REG_TAP_COUNT: begin
          tap  <= tap_clamped;
          sum  <= '0;
          wp   <= '0;
          fill <= '0;
        end
        default: ;
      endcase
    end else if (upd.upd) begin
      sum  <= sum_next;
      wp   <= wp_next;
      fill <= fill_next;
    end
  end

  // entries are only read once written since the last clear
  always_ff @(posedge clk) begin
    if (upd.upd) begin
      ring[wp] <= upd.sample;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/mavg_div.sv =====
// ----------------------------------------------------------------------------
// mavg_div: bit-serial restoring divider
// Shifts the dividend out one bit per cycle, one quotient bit back in,
// until all SUM_W dividend bits are replaced by quotient bits.
// ----------------------------------------------------------------------------
`default_nettype none

module mavg_div
  import mavg_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [SUM_W-1:0] dividend,
  input  wire logic [TAP_W-1:0] divisor,
  output logic                  done,
  output logic [SUM_W-1:0]      quotient
);

  logic [TAP_W-1:0]  dvs;
  logic [TAP_W:0]    rem;
  logic [DCNT_W-1:0] cnt;
  logic              busy;

  logic [TAP_W:0]    rem_sh;
  logic              take;

  always_comb begin
    rem_sh = {rem[TAP_W-1:0], quotient[SUM_W-1]};
    take   = (rem_sh >= {1'b0, dvs});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= DCNT_W'(SUM_W);
      end else if (busy) begin
        cnt <= cnt - DCNT_W'(1);
        if (cnt == DCNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      dvs      <= divisor;
    end else if (busy) begin
      quotient <= {quotient[SUM_W-2:0], take};
      rem      <= take ? (rem_sh - {1'b0, dvs}) : rem_sh;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/moving_average_filter.sv =====
// ----------------------------------------------------------------------------
// moving_average_filter: 16-bit moving-average filter with bypass
// One sample word in, one result word out, valid/ready on both channels.
// ----------------------------------------------------------------------------
// Channels: din takes samples, dout returns one result per sample, cfg
// writes filter_mode (index 0) and tap_count (index 1, clamped to
// 1..MAX_TAPS). cfg is always ready; write it only while no sample is in
// flight. A write to either register restarts averaging from an empty window.
// Bypass: the sample is registered into result on acceptance and then
// loaded into the output register; din takes no new word until that load.
// Averaging: the accepting edge updates ring and running sum, the next
// edge loads the bit-serial divider, which then runs at one quotient bit
// per cycle over all SUM_W (20) bits; its done flag moves the quotient
// into the result register, which then loads the output register. din
// takes no new word until the result has moved into the output register.
// The output register decouples the sides: din accepts the next word
// while a result waits on dout; if dout stalls, the finished result is
// held and din stays low-ready until it moves into the output register.
// Reset (rst, synchronous): bypass mode, tap_count 1, empty window,
// no result pending.
// ----------------------------------------------------------------------------
`default_nettype none

module moving_average_filter
  import mavg_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  mavg_in_if.sink   din,
  mavg_out_if.source dout,
  mavg_cfg_if.sink  cfg
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_START,
    ST_DIV,
    ST_DONE
  } state_t;

  state_t              state;
  logic [SAMPLE_W-1:0] result;
  mavg_upd_t           upd;
  logic                mode;
  logic [SUM_W-1:0]    sum;
  logic [TAP_W-1:0]    fill;
  logic                div_start;
  logic                div_done;
  logic [SUM_W-1:0]    quotient;
  logic                in_take;
  logic                out_free;
  logic                out_load;

  assign din.ready = (state == ST_IDLE);
  assign in_take   = din.valid && din.ready;
  assign out_free  = !dout.valid || dout.ready;
  assign out_load  = (state == ST_DONE) && out_free;
  assign div_start = (state == ST_START);

  always_comb begin
    upd.upd    = in_take && (mode == MODE_AVERAGE);
    upd.sample = din.sample_in;
  end

  mavg_state u_state (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .upd  (upd),
    .mode (mode),
    .sum  (sum),
    .fill (fill)
  );

  mavg_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sum),
    .divisor  (fill),
    .done     (div_done),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      dout.valid <= 1'b0;
    end else begin
      if (out_load) begin
        dout.valid <= 1'b1;
      end else if (dout.ready) begin
        dout.valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_take) begin
            if (mode == MODE_AVERAGE) begin
              state <= ST_START;
            end else begin
              result <= din.sample_in;
              state  <= ST_DONE;
            end
          end
        end
        ST_START: begin
          state <= ST_DIV;
        end
        ST_DIV: begin
          if (div_done) begin
            result <= quotient[SAMPLE_W-1:0];
            state  <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            dout.sample_out <= result;
            state           <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== sim/tb_moving_average_filter.sv =====
// ----------------------------------------------------------------------------
// tb_moving_average_filter: self-checking testbench for the averaging filter
// Drives sample words and register writes with random gaps and output stalls.
// A local model of the window predicts every result, and each output word is
// compared in order against those predictions.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module tb_moving_average_filter;
  import mavg_pkg::*;

  localparam int CLK_HALF      = 2;
  localparam int RESET_CYCLES  = 6;
  localparam int IDLE_CYCLES   = 4;
  localparam int SETTLE_CYCLES = 30;
  localparam int RANDOM_ITEMS  = 1000;
  localparam int HOLD_CYCLES   = 300;
  localparam int CYCLE_LIMIT   = 1_000_000;

  logic clk;
  logic rst;

  mavg_in_if  din_if ();
  mavg_out_if dout_if ();
  mavg_cfg_if cfg_if ();

  moving_average_filter i_dut (
    .clk  (clk),
    .rst  (rst),
    .din  (din_if),
    .dout (dout_if),
    .cfg  (cfg_if)
  );

  // window model
  logic                avg_mode;
  logic [TAP_W-1:0]    taps;
  logic [SAMPLE_W-1:0] ring [MAX_TAPS];
  logic [TAP_W-1:0]    wr_pos;
  logic [TAP_W-1:0]    fill;
  logic [SUM_W-1:0]    window_sum;

  logic [SAMPLE_W-1:0] expected_samples [$];
  int mismatch_count = 0;
  int cycle_count    = 0;
  int rx_hold_req    = 0;
  bit tx_idle_on     = 1'b1;
  bit rx_stall_on    = 1'b1;

  initial begin : clock_gen
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  function automatic void clear_window();
    for (int i = 0; i < MAX_TAPS; i++) ring[i] = '0;
    wr_pos     = '0;
    fill       = '0;
    window_sum = '0;
  endfunction

  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] data);
    logic [TAP_FIELD_W-1:0] t;
    case (idx)
      REG_FILTER_MODE: begin
        avg_mode = data[0];
        clear_window();
      end
      REG_TAP_COUNT: begin
        t = data[TAP_FIELD_W-1:0];
        if (t == 0) taps = TAP_W'(1);
        else if (t > MAX_TAPS) taps = TAP_W'(MAX_TAPS);
        else taps = TAP_W'(t);
        clear_window();
      end
      default: ;  // unknown index: no effect at all
    endcase
  endfunction

  function automatic logic [SAMPLE_W-1:0] filter_predict(input logic [SAMPLE_W-1:0] s);
    logic [SUM_W-1:0] quotient;
    if (avg_mode != MODE_AVERAGE) return s;
    if (wr_pos >= MAX_TAPS) wr_pos = '0;
    if (fill < taps) fill = fill + 1'b1;
    else window_sum = window_sum - ring[wr_pos];
    ring[wr_pos] = s;
    window_sum   = window_sum + s;
    wr_pos       = wr_pos + 1'b1;
    if (wr_pos >= taps) wr_pos = '0;
    quotient = window_sum / fill;
    return quotient[SAMPLE_W-1:0];
  endfunction

  // mostly zero or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return {1'b1, 15'($urandom_range(0, 7))};
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_tap_data();
    case ($urandom_range(0, 7))
      0:       return 8'd0;
      1:       return 8'd1;
      2:       return 8'd16;
      3:       return 8'd17;
      4:       return 8'd31;
      5:       return 8'hFF;
      6:       return CFG_DATA_W'($urandom_range(2, 15));
      default: return CFG_DATA_W'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch @%0d: %s", cycle_count, msg);
    mismatch_count++;
  endtask

  task automatic send_sample(input logic [SAMPLE_W-1:0] s);
    int gap;
    gap = tx_idle_on ? pick_gap() : 0;
    @(negedge clk);
    if (gap > 0) begin
      din_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    din_if.valid     <= 1'b1;
    din_if.sample_in <= s;
    do @(posedge clk); while (!(din_if.valid && din_if.ready));
    expected_samples.push_back(filter_predict(s));
  endtask

  // stop offering words and wait for every pending result
  task automatic drain_results();
    @(negedge clk);
    din_if.valid <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (IDLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk); while (!(cfg_if.valid && cfg_if.ready));
    apply_reg(idx, data);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic test_bypass_after_reset();
    send_sample(16'hFFFF);
    send_sample(16'h0000);
    drain_results();
  endtask

  task automatic test_unit_window();
    write_reg(REG_FILTER_MODE, 8'h01);
    send_sample(16'hFFFF);
    send_sample(16'h1234);
    drain_results();
    write_reg(REG_TAP_COUNT, 8'h00);  // clamps up to one tap
    send_sample(16'hA5A5);
    drain_results();
  endtask

  task automatic test_full_window();
    write_reg(REG_TAP_COUNT, 8'hFF);  // clamps down to MAX_TAPS
    // all-ones fill reaches the largest sum, then wraps the ring once
    for (int i = 0; i < MAX_TAPS + 1; i++) send_sample(16'hFFFF);
    drain_results();
  endtask

  task automatic test_ignored_index();
    write_reg(CFG_IDX_W'(2), 8'h00);
    write_reg(CFG_IDX_W'(255), 8'hFF);
    send_sample(16'h0000);  // window must carry on, not restart
    drain_results();
  endtask

  task automatic test_mode_switch();
    write_reg(REG_FILTER_MODE, 8'hFE);  // only bit 0 counts: bypass
    send_sample(16'h8001);
    drain_results();
    write_reg(REG_FILTER_MODE, 8'h03);
    send_sample(16'h7FFE);
    drain_results();
  endtask

  task automatic test_backpressure();
    write_reg(REG_TAP_COUNT, CFG_DATA_W'($urandom_range(1, 16)));
    write_reg(REG_FILTER_MODE, 8'h01);
    tx_idle_on  = 1'b0;
    rx_hold_req = HOLD_CYCLES;
    for (int i = 0; i < 8; i++) send_sample(pick_sample());
    tx_idle_on = 1'b1;
    drain_results();
  endtask

  task automatic test_random_phases();
    int sent;
    int n;
    logic [CFG_DATA_W-1:0] mode_data;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      drain_results();
      mode_data    = CFG_DATA_W'($urandom_range(0, 255));
      mode_data[0] = ($urandom_range(0, 4) != 0);
      case ($urandom_range(0, 3))
        0: write_reg(REG_FILTER_MODE, mode_data);
        1: write_reg(REG_TAP_COUNT, pick_tap_data());
        2: begin
          write_reg(REG_FILTER_MODE, mode_data);
          write_reg(REG_TAP_COUNT, pick_tap_data());
        end
        default: begin
          write_reg(REG_TAP_COUNT, pick_tap_data());
          write_reg(REG_FILTER_MODE, mode_data);
        end
      endcase
      if ($urandom_range(0, 7) == 0)
        write_reg(CFG_IDX_W'($urandom_range(2, 255)), CFG_DATA_W'($urandom_range(0, 255)));
      tx_idle_on  = ($urandom_range(0, 3) != 0);
      rx_stall_on = ($urandom_range(0, 3) != 0);
      n = $urandom_range(5, 60);
      for (int k = 0; k < n; k++) send_sample(pick_sample());
      sent += n;
    end
    tx_idle_on  = 1'b1;
    rx_stall_on = 1'b1;
  endtask

  initial begin : output_sink
    int stall_left;
    int hold_left;
    stall_left    = 0;
    hold_left     = 0;
    dout_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_req > 0) begin
        hold_left   = rx_hold_req;
        rx_hold_req = 0;
      end
      if (hold_left > 0) begin
        dout_if.ready <= 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        dout_if.ready <= 1'b0;
        stall_left--;
      end else if (rx_stall_on && $urandom_range(0, 3) == 0) begin
        dout_if.ready <= 1'b0;
        stall_left = pick_gap();
      end else begin
        dout_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : check_output
    logic [SAMPLE_W-1:0] want;
    if (!rst && dout_if.valid && dout_if.ready) begin
      if (expected_samples.size() == 0) begin
        report_mismatch($sformatf("unexpected word %h", dout_if.sample_out));
      end else begin
        want = expected_samples.pop_front();
        if (dout_if.sample_out !== want)
          report_mismatch($sformatf("sample_out %h, want %h", dout_if.sample_out, want));
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin : run_regression
    rst              = 1'b1;
    din_if.valid     = 1'b0;
    din_if.sample_in = '0;
    cfg_if.valid     = 1'b0;
    cfg_if.index     = '0;
    cfg_if.data      = '0;
    avg_mode         = MODE_BYPASS;
    taps             = TAP_W'(1);
    clear_window();
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_bypass_after_reset();
    test_unit_window();
    test_full_window();
    test_ignored_index();
    test_mode_switch();
    test_backpressure();
    test_random_phases();

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
